@@ src/tvpf_pkg.sv @@
package tvpf_pkg;
    localparam int unsigned ADDR_W = 15;
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_FILTER = 1'b1;

    localparam logic [2:0] REG_ORG_X = 3'd0;
    localparam logic [2:0] REG_ORG_Y = 3'd1;
    localparam logic [2:0] REG_ORG_Z = 3'd2;
    localparam logic [2:0] REG_CPU_X = 3'd3;
    localparam logic [2:0] REG_CPU_Y = 3'd4;
    localparam logic [2:0] REG_CPU_Z = 3'd5;
    localparam logic [2:0] REG_VMIN  = 3'd6;
    localparam logic [2:0] REG_VMAX  = 3'd7;

    typedef struct packed {
        logic        command;
        logic [14:0] voxel_address;
        logic [31:0] voxel_value;
        logic        voxel_is_byte;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] radius_in;
    } t_in;

    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic [31:0] out_radius;
        logic        kept;
    } t_out;

    // Shared multiplier request: a is a coordinate offset or a voxel difference,
    // b is a scale or a fraction.
    typedef struct packed {
        logic signed [36:0] a;
        logic signed [33:0] b;
    } t_mul_req;
endpackage

@@ src/tvpf_if.sv @@
interface tvpf_in_if import tvpf_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tvpf_out_if import tvpf_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/tvpf_mul.sv @@
// Shared registered signed multiplier used by every product of the sequencer.
module tvpf_mul import tvpf_pkg::*; (
    input  logic               i_clk,
    input  t_mul_req           i_req,
    output logic signed [70:0] o_prod
);
    logic signed [70:0] r_prod;
    always_ff @(posedge i_clk) begin
        r_prod <= i_req.a * i_req.b;
    end
    assign o_prod = r_prod;
endmodule

@@ src/trilinear_volume_particle_filter_top.sv @@
// Trilinear volume threshold filter.
// Requests arrive on the in channel (valid/ready). A load request writes one
// voxel into the internal 32768-word volume memory and produces no result.
// A filter request maps the particle position into grid coordinates, reads
// the eight clamped neighbor voxels one at a time from the single-port
// memory, interpolates along x, y and z and compares against value_min and
// value_max. Its result leaves on the out channel.
// A load writes its voxel, then the block returns to idle. A filter request
// works in order: three coordinate products on the one shared multiplier,
// the eight reads of the single memory port, seven interpolation products on
// the same multiplier, then the compare into the output register. Each product
// and each read word is registered before it is used.
// Ready stays low while a request is being worked on. A finished result sits
// in the output register; when the receiver stalls, the block waits with it
// and takes no new request until the result is taken.
// Reset (synchronous, active low) returns the sequencer to idle and the
// configuration registers to their reset values. The volume is not cleared:
// voxels must be loaded before they are read. The user must write the
// configuration through the APB port while the block is idle; the block does not enforce it.
module trilinear_volume_particle_filter_top import tvpf_pkg::*; #(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tvpf_in_if.sink      i_in,
    tvpf_out_if.source   o_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam logic [3:0] S_IDLE = 4'd0, S_LOAD = 4'd1, S_GMUL = 4'd2,
        S_GRES = 4'd3, S_RD = 4'd4, S_RDW = 4'd5, S_LMUL = 4'd6,
        S_LRES = 4'd7, S_CMP = 4'd8, S_OUT = 4'd9;

    logic [31:0] r_cfg [8];
    logic [3:0]  r_state;
    t_in         r_req;
    t_out        r_out;
    logic [1:0]  r_ax;
    logic [2:0]  r_cnt;
    logic signed [33:0] r_frac [3];
    logic signed [35:0] r_ip [3];
    logic signed [36:0] r_v [8];
    logic [31:0] r_mem [32768];
    logic [31:0] r_rdata;
    logic [14:0] r_waddr;
    logic [31:0] r_wdata;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = r_cfg[paddr[4:2]];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_ORG_X] <= 32'd0;
            r_cfg[REG_ORG_Y] <= 32'd0;
            r_cfg[REG_ORG_Z] <= 32'd0;
            r_cfg[REG_CPU_X] <= 32'd2097152;
            r_cfg[REG_CPU_Y] <= 32'd2097152;
            r_cfg[REG_CPU_Z] <= 32'd2097152;
            r_cfg[REG_VMIN]  <= 32'd0;
            r_cfg[REG_VMAX]  <= 32'd65536;
        end else if (psel && penable && pwrite) begin
            r_cfg[paddr[4:2]] <= pwdata;
        end
    end

    // Shared multiplier.
    t_mul_req            w_req;
    logic signed [70:0]  w_prod;
    tvpf_mul u_mul (.i_clk(i_clk), .i_req(w_req), .o_prod(w_prod));

    // Interpolation pair: step r_cnt of seven.
    logic [2:0] w_la, w_lb;
    logic [1:0] w_lf;
    always_comb begin
        case (r_cnt)
            3'd0: begin w_la = 3'd0; w_lb = 3'd1; w_lf = 2'd0; end
            3'd1: begin w_la = 3'd2; w_lb = 3'd3; w_lf = 2'd0; end
            3'd2: begin w_la = 3'd4; w_lb = 3'd5; w_lf = 2'd0; end
            3'd3: begin w_la = 3'd6; w_lb = 3'd7; w_lf = 2'd0; end
            3'd4: begin w_la = 3'd0; w_lb = 3'd2; w_lf = 2'd1; end
            3'd5: begin w_la = 3'd4; w_lb = 3'd6; w_lf = 2'd1; end
            default: begin w_la = 3'd0; w_lb = 3'd4; w_lf = 2'd2; end
        endcase
    end

    logic signed [32:0] w_d;
    logic [31:0] w_pos, w_org;
    always_comb begin
        w_pos = (r_ax == 2'd0) ? r_req.pos_x : (r_ax == 2'd1) ? r_req.pos_y : r_req.pos_z;
        w_org = r_cfg[{1'b0, r_ax}];
        w_d   = $signed({w_pos[31], w_pos}) - $signed({w_org[31], w_org});
        if (r_state == S_GMUL) begin
            w_req.a = {{4{w_d[32]}}, w_d};
            w_req.b = $signed({2'b00, r_cfg[3'd3 + {1'b0, r_ax}]});
        end else begin
            w_req.a = r_v[w_lb] - r_v[w_la];
            w_req.b = r_frac[w_lf];
        end
    end

    // Grid coordinate: floor(prod/65536) - 1/2, then truncating split.
    logic signed [51:0] w_g;
    logic signed [51:0] w_gabs;
    logic signed [35:0] w_ipw;
    logic signed [33:0] w_fr;
    always_comb begin
        w_g    = 52'(w_prod >>> 16) - 52'sd32768;
        w_gabs = w_g[51] ? -w_g : w_g;
        w_ipw  = w_g[51] ? -$signed({1'b0, w_gabs[50:16]}) : $signed({1'b0, w_gabs[50:16]});
        w_fr   = w_g[51] ? -$signed({17'd0, w_gabs[15:0]}) : $signed({17'd0, w_gabs[15:0]});
    end

    // Clamped neighbor index per axis.
    function automatic logic [31:0] clampi(input logic signed [35:0] i, input int sz);
        logic signed [36:0] s;
        begin
            s = {i[35], i};
            if (s < 0) clampi = 32'd0;
            else if (s >= sz) clampi = 32'(sz - 1);
            else clampi = i[31:0];
        end
    endfunction

    logic [31:0] w_cx, w_cy, w_cz;
    logic [14:0] w_raddr;
    always_comb begin
        w_cx = clampi(r_ip[0] + 36'(r_cnt[0]), GRID_X);
        w_cy = clampi(r_ip[1] + 36'(r_cnt[1]), GRID_Y);
        w_cz = clampi(r_ip[2] + 36'(r_cnt[2]), GRID_Z);
        w_raddr = 15'(w_cx[14:0] + 15'(GRID_X) * 15'(w_cy[14:0] + 15'(GRID_Y) * w_cz[14:0]));
    end

    // Byte scaling: round(b*65536/255) as floor((b*65536+127)/255), taken by
    // a reciprocal multiply with ceil(2^32/255) that is exact below 2^24.
    logic [7:0]  w_b;
    logic [23:0] w_bx;
    logic [48:0] w_bs;
    logic [31:0] w_word;
    assign w_b    = i_in.data.voxel_value[7:0];
    assign w_bx   = {w_b, 16'd0} + 24'd127;
    assign w_bs   = {25'd0, w_bx} * 49'd16843010;
    assign w_word = i_in.data.voxel_is_byte ? {15'd0, w_bs[48:32]} : i_in.data.voxel_value;

    // Single-port volume memory.
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) r_mem[r_waddr] <= r_wdata;
        else r_rdata <= r_mem[w_raddr];
    end

    logic signed [36:0] w_lerp;
    assign w_lerp = r_v[w_la] + 37'(w_prod >>> 16);

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_OUT);
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ax    <= 2'd0;
            r_cnt   <= 3'd0;
        end else begin
            case (r_state)
                S_IDLE: if (i_in.valid) begin
                    r_req   <= i_in.data;
                    r_waddr <= i_in.data.voxel_address;
                    r_wdata <= w_word;
                    r_ax    <= 2'd0;
                    r_cnt   <= 3'd0;
                    r_state <= (i_in.data.command == CMD_LOAD) ? S_LOAD : S_GMUL;
                end
                S_LOAD: r_state <= S_IDLE;
                S_GMUL: r_state <= S_GRES;
                S_GRES: begin
                    r_ip[r_ax]   <= w_ipw;
                    r_frac[r_ax] <= w_fr;
                    if (r_ax == 2'd2) r_state <= S_RD;
                    else begin r_ax <= r_ax + 2'd1; r_state <= S_GMUL; end
                end
                S_RD: r_state <= S_RDW;
                S_RDW: begin
                    r_v[r_cnt] <= {{5{r_rdata[31]}}, r_rdata};
                    r_cnt <= r_cnt + 3'd1;
                    r_state <= (r_cnt == 3'd7) ? S_LMUL : S_RD;
                end
                S_LMUL: r_state <= S_LRES;
                S_LRES: begin
                    r_v[w_la] <= w_lerp;
                    r_cnt <= r_cnt + 3'd1;
                    r_state <= (r_cnt == 3'd6) ? S_CMP : S_LMUL;
                end
                S_CMP: begin
                    r_out.out_x <= r_req.pos_x;
                    r_out.out_y <= r_req.pos_y;
                    r_out.out_z <= r_req.pos_z;
                    if (r_v[0] < $signed({{5{r_cfg[REG_VMIN][31]}}, r_cfg[REG_VMIN]}) ||
                        r_v[0] > $signed({{5{r_cfg[REG_VMAX][31]}}, r_cfg[REG_VMAX]})) begin
                        r_out.kept <= 1'b0;
                        r_out.out_radius <= 32'd0;
                    end else begin
                        r_out.kept <= 1'b1;
                        r_out.out_radius <= r_req.radius_in;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: if (o_out.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The sequencer is never ready while a result is pending.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready) else $error("ready while result pending");
    // A load never produces a result on the next cycle.
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |=> !o_out.valid) else $error("load made a result");
    // A pending result holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(r_out)))
        else $error("result dropped");
endmodule

@@ sim/trilinear_volume_particle_filter_top_tb.sv @@
`timescale 1ns / 100ps

module trilinear_volume_particle_filter_top_tb;
    import tvpf_pkg::*;

    localparam int GRID_SIZE  = 32;
    localparam int VOXELS     = 32768;
    localparam int ONE_Q16    = 65536;
    localparam longint CYCLE_LIMIT = 1500000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tvpf_in_if  in_if();
    tvpf_out_if out_if();

    trilinear_volume_particle_filter_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copies of the configuration registers and of the volume memory.
    logic [31:0] cfg_shadow [8];
    logic [31:0] volume_shadow [VOXELS];

    // Filter results that have been predicted but not yet seen on the out channel.
    t_out pending_results [$];

    int     send_idle_pct;
    int     recv_idle_pct;
    int     mismatch_count;
    longint cycle_count;

    always #2 i_clk = ~i_clk;

    // A run that hangs on a handshake is stopped here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatch_count++;
    endtask

    // One interpolation step: a + floor((b - a) * f / 2^16).
    function automatic longint lerp_q16(input longint a, input longint b, input longint f);
        return a + (((b - a) * f) >>> 16);
    endfunction

    function automatic longint clamp_index(input longint i);
        if (i < 0) return 0;
        if (i >= GRID_SIZE) return GRID_SIZE - 1;
        return i;
    endfunction

    // Predicts the result of one filter request from the shadow state.
    function automatic t_out predict_filter(input t_in req);
        longint      pos [3];
        longint      whole [3];
        longint      frac [3];
        longint      corner [8];
        longint      d;
        longint      g;
        longint      addr;
        logic [63:0] d_mag;
        logic [63:0] prod;
        t_out        res;
        bit          kept;
        pos[0] = longint'($signed(req.pos_x));
        pos[1] = longint'($signed(req.pos_y));
        pos[2] = longint'($signed(req.pos_z));
        for (int k = 0; k < 3; k++) begin
            d = pos[k] - longint'($signed(cfg_shadow[REG_ORG_X + k]));
            d_mag = (d < 0) ? -d : d;
            prod = d_mag * {32'd0, cfg_shadow[REG_CPU_X + k]};
            // The exact product is rounded toward minus infinity, then the half cell goes.
            if (d >= 0) g = longint'(prod >> 16);
            else g = -longint'((prod + 64'd65535) >> 16);
            g = g - ONE_Q16 / 2;
            whole[k] = g / ONE_Q16;
            frac[k] = g - whole[k] * ONE_Q16;
        end
        for (int oz = 0; oz < 2; oz++) begin
            for (int oy = 0; oy < 2; oy++) begin
                for (int ox = 0; ox < 2; ox++) begin
                    addr = clamp_index(whole[0] + ox) + GRID_SIZE * (clamp_index(whole[1] + oy)
                           + GRID_SIZE * clamp_index(whole[2] + oz));
                    corner[ox + 2 * (oy + 2 * oz)] =
                        longint'($signed(volume_shadow[addr & (VOXELS - 1)]));
                end
            end
        end
        corner[0] = lerp_q16(corner[0], corner[1], frac[0]);
        corner[2] = lerp_q16(corner[2], corner[3], frac[0]);
        corner[4] = lerp_q16(corner[4], corner[5], frac[0]);
        corner[6] = lerp_q16(corner[6], corner[7], frac[0]);
        corner[0] = lerp_q16(corner[0], corner[2], frac[1]);
        corner[4] = lerp_q16(corner[4], corner[6], frac[1]);
        corner[0] = lerp_q16(corner[0], corner[4], frac[2]);
        kept = !(corner[0] < longint'($signed(cfg_shadow[REG_VMIN])) ||
                 corner[0] > longint'($signed(cfg_shadow[REG_VMAX])));
        res.out_x = req.pos_x;
        res.out_y = req.pos_y;
        res.out_z = req.pos_z;
        res.out_radius = kept ? req.radius_in : 32'd0;
        res.kept = kept;
        return res;
    endfunction

    function automatic logic [31:0] stored_word(input t_in req);
        logic [23:0] scaled;
        if (req.voxel_is_byte) begin
            scaled = ({req.voxel_value[7:0], 16'd0} + 24'd127) / 24'd255;
            return {8'd0, scaled};
        end
        return req.voxel_value;
    endfunction

    // Sends one request and updates the shadow state when it is accepted.
    task automatic send_request(input t_in req);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data <= req;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (req.command == CMD_LOAD) volume_shadow[req.voxel_address] = stored_word(req);
        else pending_results.push_back(predict_filter(req));
    endtask

    function automatic t_in make_load(input logic [14:0] addr, input logic [31:0] value,
                                      input logic is_byte);
        t_in req;
        logic [191:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        req = noise[$bits(t_in)-1:0];
        req.command = CMD_LOAD;
        req.voxel_address = addr;
        req.voxel_value = value;
        req.voxel_is_byte = is_byte;
        return req;
    endfunction

    function automatic t_in make_particle(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z, input logic [31:0] r);
        t_in req;
        logic [191:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        req = noise[$bits(t_in)-1:0];
        req.command = CMD_FILTER;
        req.pos_x = x;
        req.pos_y = y;
        req.pos_z = z;
        req.radius_in = r;
        return req;
    endfunction

    // Waits until every result is in and any load still in flight has finished.
    task automatic drain;
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // APB write: the setup phase, then the access phase held until pready, then
    // an idle phase.
    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        cfg_shadow[index] = value;
    endtask

    task automatic write_all_registers(input logic [31:0] org, input logic [31:0] cpu,
                                       input logic [31:0] vmin, input logic [31:0] vmax);
        write_register(REG_ORG_X, org);
        write_register(REG_ORG_Y, org);
        write_register(REG_ORG_Z, org);
        write_register(REG_CPU_X, cpu);
        write_register(REG_CPU_Y, cpu);
        write_register(REG_CPU_Z, cpu);
        write_register(REG_VMIN, vmin);
        write_register(REG_VMAX, vmax);
    endtask

    // Picks a position whose grid coordinate lands near the low or the high
    // end of the grid, so that interpolation between distinct voxels is
    // exercised while every index stays in 0..3 or 28..31.
    function automatic logic [31:0] position_near_grid(input int axis);
        longint target;
        longint p;
        if ($urandom_range(1) == 0) target = longint'($urandom_range(5 * ONE_Q16 - 1)) - 2 * ONE_Q16;
        else target = longint'($urandom_range(5 * ONE_Q16 - 1)) + 29 * ONE_Q16;
        if (cfg_shadow[REG_CPU_X + axis] == 0) return $urandom;
        if ($urandom_range(99) < 12) return ($urandom_range(1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        p = longint'($signed(cfg_shadow[REG_ORG_X + axis])) +
            (target <<< 16) / longint'({32'd0, cfg_shadow[REG_CPU_X + axis]});
        if (p > 64'sd2147483647) p = 64'sd2147483647;
        if (p < -64'sd2147483648) p = -64'sd2147483648;
        return p[31:0];
    endfunction

    function automatic logic [31:0] small_sample();
        if ($urandom_range(99) < 8) return $urandom;
        return $urandom_range(4 * ONE_Q16) - 2 * ONE_Q16;
    endfunction

    // Bar one directed case at z 19..20, filter requests read only voxels whose
    // indices all lie in 0..3 or 28..31, each written before any filter request.
    task automatic test_fill_volume;
        int idx [8];
        idx = '{0, 1, 2, 3, 28, 29, 30, 31};
        for (int z = 0; z < 8; z++) begin
            for (int y = 0; y < 8; y++) begin
                for (int x = 0; x < 8; x++) begin
                    send_request(make_load(15'(idx[x] + GRID_SIZE * (idx[y] + GRID_SIZE * idx[z])),
                                           small_sample(), ($urandom_range(9) == 0)));
                end
            end
        end
    endtask

    // Field extremes and the special cases: reset configuration, then zero and largest scale.
    task automatic test_directed;
        send_request(make_load(15'd0, 32'h7FFF_FFFF, 1'b0));
        send_request(make_load(15'd1, 32'h8000_0000, 1'b0));
        // Byte sample with junk in the upper bits.
        send_request(make_load(15'd32, 32'hFFFF_FFFF, 1'b1));
        send_request(make_load(15'd33, 32'h1234_5600, 1'b1));
        send_request(make_load(15'd32767, 32'h0001_0000, 1'b0));
        // A position at the origin gives a coordinate of minus one half.
        send_request(make_particle(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF));
        send_request(make_particle(32'd3072, 32'd3072, 32'd3072, 32'd0));
        send_request(make_particle(32'd1000, 32'd0, 32'd0, 32'h0001_0000));
        // Far outside on either side: an index past the grid clamps to its edge.
        send_request(make_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1));
        send_request(make_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h2));
        send_request(make_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'd40000, 32'h3));
        send_request(make_particle(32'd65535, 32'd65535, 32'd65535, 32'h4));
        send_request(make_particle(32'd60000, 32'd2100, 32'd500, 32'h5));
        drain();
        // Zero scale and reversed bounds: every particle is dropped.
        write_all_registers(32'h8000_0000, 32'd0, 32'h0001_0000, 32'h0000_0000);
        send_request(make_particle(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF));
        send_request(make_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'd5, 32'h7));
        drain();
        // Largest scale with an origin at the top of the range.
        write_all_registers(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(make_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8));
        send_request(make_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h9));
        send_request(make_particle(32'h7FFF_FFF0, 32'h7FFF_FFFF, 32'h7FFF_FF00, 32'hA));
        drain();
    endtask

    // Mostly particles near the grid, with loads mixed in.
    task automatic test_random(input int items);
        for (int n = 0; n < items; n++) begin
            if ($urandom_range(99) < 25) begin
                send_request(make_load(15'($urandom), small_sample(), 1'($urandom_range(1))));
            end else begin
                send_request(make_particle(position_near_grid(0), position_near_grid(1),
                                           position_near_grid(2), $urandom));
            end
        end
        drain();
    endtask

    // Checks each result against the oldest prediction and stalls at random.
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", out_if.data.out_x, 32'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (out_if.data.out_x !== want.out_x)
                        report_mismatch("out_x", out_if.data.out_x, want.out_x);
                    if (out_if.data.out_y !== want.out_y)
                        report_mismatch("out_y", out_if.data.out_y, want.out_y);
                    if (out_if.data.out_z !== want.out_z)
                        report_mismatch("out_z", out_if.data.out_z, want.out_z);
                    if (out_if.data.out_radius !== want.out_radius)
                        report_mismatch("out_radius", out_if.data.out_radius, want.out_radius);
                    if (out_if.data.kept !== want.kept)
                        report_mismatch("kept", {31'd0, out_if.data.kept}, {31'd0, want.kept});
                end
            end
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        send_idle_pct = 19;
        recv_idle_pct = 49;
        cfg_shadow = '{32'd0, 32'd0, 32'd0, 32'd2097152, 32'd2097152, 32'd2097152,
                       32'd0, 32'd65536};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_volume();
        test_directed();

        write_all_registers(32'hFFFF_8000, 32'd2097152, 32'hFFFF_8000, 32'h0001_0000);
        test_random(400);

        send_idle_pct = 49;
        recv_idle_pct = 19;
        write_all_registers(32'h0123_4567, 32'h0000_8000, 32'hFFFE_0000, 32'h0000_4000);
        test_random(350);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all_registers(32'hF000_0000, 32'h0040_0000, 32'h0000_0000, 32'h0002_0000);
        test_random(320);

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

@@ files.f @@
src/tvpf_pkg.sv
src/tvpf_if.sv
src/tvpf_mul.sv
src/trilinear_volume_particle_filter_top.sv
sim/trilinear_volume_particle_filter_top_tb.sv
